[rtl/htw_pkg.sv]
// Package for the hashed timing wheel: command/result words, codes,
// sequencer states. No dependencies.
`default_nettype none
package htw_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_TAKE   = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TAKE   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_code_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EARLY  = 2'd1,
        ST_PAST   = 2'd2,
        ST_BEYOND = 2'd3
    } status_code_t;

    localparam int TIME_W   = 48;
    localparam int HANDLE_W = 6;

    typedef struct packed {
        logic [1:0]          command;
        logic [TIME_W-1:0]   now_ms;
        logic [TIME_W-1:0]   expire_ms;
        logic [HANDLE_W-1:0] timer_handle;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [HANDLE_W-1:0] expired_handle;
        logic                expired_valid;
        logic                last;
    } res_word_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INIT,
        S_ADD_NOW, S_ADD_EXP, S_ADD_DIFF, S_ADD_SLOT, S_ADD_RD, S_ADD_WR1, S_ADD_WR2,
        S_CAN_RD, S_CAN_HS, S_CAN_WR1, S_CAN_WR2,
        S_TK_SPAN, S_TS_RD, S_TS_HEAD, S_TH_RD, S_TH_DATA, S_TH_EMIT, S_TK_NEXT,
        S_TK_FIN, S_EMIT
    } seq_state_t;

    function automatic res_word_t mk_res(input kind_code_t k, input status_code_t s,
                                         input logic [HANDLE_W-1:0] h, input logic v,
                                         input logic l);
        res_word_t r;
        r.kind           = k;
        r.status         = s;
        r.expired_handle = h;
        r.expired_valid  = v;
        r.last           = l;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/hashed_timing_wheel.sv]
// Top level of the hashed timing wheel: sequencer, slot and handle memories.
// Depends on htw_pkg and htw_sub.
`default_nettype none
// Single-level timing wheel, one slot per millisecond, each slot a FIFO of
// timer handles kept as a doubly linked list in per-handle next/prev memories.
// Commands arrive one word at a time and are worked by a small sequencer
// around one shared 48-bit subtractor; cmd_stall stays high until the
// command's last result word has gone into the output register. After reset
// a clearing pass over max(WHEEL_SLOTS, MAX_TIMERS) addresses empties the slot
// and handle memories before the first command is taken. The memories have
// registered reads. A take walks up to WHEEL_SLOTS slots, and a stalled
// result side holds any command back.
module hashed_timing_wheel
    import htw_pkg::*;
#(
    parameter int WHEEL_SLOTS = 1024,
    parameter int MAX_TIMERS  = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_word_t cmd,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_word_t      res
);
    localparam int SW    = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int HW    = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int LW    = HW + 1;
    localparam int CLR_N = (WHEEL_SLOTS > MAX_TIMERS) ? WHEEL_SLOTS : MAX_TIMERS;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [LW-1:0] LINK_NONE = {1'b1, {HW{1'b0}}};

    // ---- memories ----
    logic [2*LW-1:0] slot_mem [WHEEL_SLOTS];   // {head, tail}
    logic [LW-1:0]   next_mem [MAX_TIMERS];
    logic [LW-1:0]   prev_mem [MAX_TIMERS];
    logic [SW:0]     hslot_mem[MAX_TIMERS];    // {linked, slot}

    logic            slot_we;
    logic [SW-1:0]   slot_waddr, slot_raddr;
    logic [2*LW-1:0] slot_wdata, slot_rd;
    logic            next_we, prev_we, hslot_we;
    logic [HW-1:0]   next_waddr, prev_waddr, hslot_waddr, h_raddr;
    logic [LW-1:0]   next_wdata, prev_wdata, next_rd, prev_rd;
    logic [SW:0]     hslot_wdata, hslot_rd;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd <= next_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd <= prev_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hslot_we)
        begin
            hslot_mem[hslot_waddr] <= hslot_wdata;
        end
        hslot_rd <= hslot_mem[h_raddr];
    end

    // ---- registers ----
    seq_state_t      state_reg, state_next;
    cmd_word_t       cmd_reg, cmd_next;
    logic [TIME_W-1:0] start_ms_reg, start_ms_next;
    logic [SW-1:0]   start_slot_reg, start_slot_next;
    logic [CW-1:0]   clr_reg, clr_next;
    logic [SW-1:0]   tgt_reg, tgt_next;       // add target slot
    logic [SW-1:0]   cur_reg, cur_next;       // take walk slot
    logic [SW-1:0]   rem_reg, rem_next;       // slots left after cur
    logic [SW-1:0]   hs_reg, hs_next;         // cancel: slot of handle
    logic [LW-1:0]   t_reg, t_next, p_reg, p_next, n_reg, n_next, h_reg, h_next;
    logic [HW-1:0]   pend_reg, pend_next;     // take: held-back handle
    logic            pend_valid_reg, pend_valid_next;
    res_word_t       res_hold_reg, res_hold_next;
    logic            res_valid_reg;
    res_word_t       res_reg;

    logic            out_free, out_load;
    res_word_t       out_word;

    logic [TIME_W-1:0] sub_a, sub_b, sub_diff;
    logic            sub_borrow;

    htw_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    logic [HW-1:0]   cmd_h;
    logic            cmd_h_ok;
    logic [SW:0]     slot_sum;
    logic [LW-1:0]   rd_head, rd_tail;

    assign cmd_h    = cmd_reg.timer_handle[HW-1:0];
    assign cmd_h_ok = {1'b0, cmd_reg.timer_handle} < (HANDLE_W + 1)'(MAX_TIMERS);
    assign slot_sum = {1'b0, start_slot_reg} + {1'b0, tgt_reg};
    assign rd_head  = slot_rd[2*LW-1:LW];
    assign rd_tail  = slot_rd[LW-1:0];
    assign out_free = !res_valid_reg || !res_stall;

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        start_ms_next   = start_ms_reg;
        start_slot_next = start_slot_reg;
        clr_next        = clr_reg;
        tgt_next        = tgt_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        hs_next         = hs_reg;
        t_next          = t_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        h_next          = h_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_hold_next   = res_hold_reg;
        out_load        = 1'b0;
        out_word        = res_hold_reg;
        sub_a           = cmd_reg.now_ms;
        sub_b           = start_ms_reg;
        slot_we         = 1'b0;
        slot_waddr      = cur_reg;
        slot_wdata      = {LINK_NONE, LINK_NONE};
        slot_raddr      = cur_reg;
        next_we         = 1'b0;
        next_waddr      = h_reg[HW-1:0];
        next_wdata      = LINK_NONE;
        prev_we         = 1'b0;
        prev_waddr      = h_reg[HW-1:0];
        prev_wdata      = LINK_NONE;
        hslot_we        = 1'b0;
        hslot_waddr     = h_reg[HW-1:0];
        hslot_wdata     = '0;
        h_raddr         = cmd_h;

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_waddr  = clr_reg[SW-1:0];
                next_waddr  = clr_reg[HW-1:0];
                prev_waddr  = clr_reg[HW-1:0];
                hslot_waddr = clr_reg[HW-1:0];
                slot_we  = {1'b0, clr_reg} < (CW + 1)'(WHEEL_SLOTS);
                next_we  = {1'b0, clr_reg} < (CW + 1)'(MAX_TIMERS);
                prev_we  = next_we;
                hslot_we = next_we;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    unique case (cmd.command)
                        CMD_ADD, CMD_TAKE: state_next = S_INIT;
                        CMD_CANCEL:        state_next = S_CAN_RD;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT:
            begin
                if (start_ms_reg == '0)
                begin
                    start_ms_next   = cmd_reg.now_ms;
                    start_slot_next = '0;
                end
                state_next = (cmd_reg.command == CMD_ADD) ? S_ADD_NOW : S_TK_SPAN;
            end
            S_ADD_NOW:
            begin
                if (sub_borrow)
                begin
                    res_hold_next = mk_res(KIND_ADD, ST_EARLY, '0, 1'b0, 1'b1);
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_ADD_EXP;
                end
            end
            S_ADD_EXP:
            begin
                sub_a = cmd_reg.expire_ms;
                sub_b = cmd_reg.now_ms;
                if (sub_borrow)
                begin
                    res_hold_next = mk_res(KIND_ADD, ST_PAST, '0, 1'b0, 1'b1);
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_ADD_DIFF;
                end
            end
            S_ADD_DIFF:
            begin
                sub_a = cmd_reg.expire_ms;
                tgt_next = sub_diff[SW-1:0];
                if (sub_diff >= TIME_W'(WHEEL_SLOTS))
                begin
                    res_hold_next = mk_res(KIND_ADD, ST_BEYOND, '0, 1'b0, 1'b1);
                    state_next    = S_EMIT;
                end
                else
                begin
                    res_hold_next = mk_res(KIND_ADD, ST_OK, '0, 1'b0, 1'b1);
                    state_next    = cmd_h_ok ? S_ADD_SLOT : S_EMIT;
                end
            end
            S_ADD_SLOT:
            begin
                // start slot + offset, folded once into range
                if (slot_sum >= (SW + 1)'(WHEEL_SLOTS))
                begin
                    tgt_next = SW'(slot_sum - (SW + 1)'(WHEEL_SLOTS));
                end
                else
                begin
                    tgt_next = slot_sum[SW-1:0];
                end
                state_next = S_ADD_RD;
            end
            S_ADD_RD:
            begin
                slot_raddr = tgt_reg;
                state_next = S_ADD_WR1;
            end
            S_ADD_WR1:
            begin
                if (hslot_rd[SW])
                begin
                    state_next = S_EMIT;   // already linked: left in place
                end
                else
                begin
                    slot_we     = 1'b1;
                    slot_waddr  = tgt_reg;
                    slot_wdata  = {(rd_tail[HW] ? {1'b0, cmd_h} : rd_head), {1'b0, cmd_h}};
                    next_we     = 1'b1;
                    next_waddr  = cmd_h;
                    prev_we     = 1'b1;
                    prev_waddr  = cmd_h;
                    prev_wdata  = rd_tail;
                    hslot_we    = 1'b1;
                    hslot_waddr = cmd_h;
                    hslot_wdata = {1'b1, tgt_reg};
                    t_next      = rd_tail;
                    state_next  = rd_tail[HW] ? S_EMIT : S_ADD_WR2;
                end
            end
            S_ADD_WR2:
            begin
                next_we    = 1'b1;
                next_waddr = t_reg[HW-1:0];
                next_wdata = {1'b0, cmd_h};
                state_next = S_EMIT;
            end
            S_CAN_RD:
            begin
                res_hold_next = mk_res(KIND_CANCEL, ST_OK, '0, 1'b0, 1'b1);
                state_next    = cmd_h_ok ? S_CAN_HS : S_EMIT;
            end
            S_CAN_HS:
            begin
                p_next     = prev_rd;
                n_next     = next_rd;
                hs_next    = hslot_rd[SW-1:0];
                slot_raddr = hslot_rd[SW-1:0];
                state_next = hslot_rd[SW] ? S_CAN_WR1 : S_EMIT;
            end
            S_CAN_WR1:
            begin
                slot_we    = 1'b1;
                slot_waddr = hs_reg;
                slot_wdata = {(p_reg[HW] ? n_reg : rd_head), (n_reg[HW] ? p_reg : rd_tail)};
                next_we    = !p_reg[HW];
                next_waddr = p_reg[HW-1:0];
                next_wdata = n_reg;
                prev_we    = !n_reg[HW];
                prev_waddr = n_reg[HW-1:0];
                prev_wdata = p_reg;
                state_next = S_CAN_WR2;
            end
            S_CAN_WR2:
            begin
                next_we     = 1'b1;
                next_waddr  = cmd_h;
                prev_we     = 1'b1;
                prev_waddr  = cmd_h;
                hslot_we    = 1'b1;
                hslot_waddr = cmd_h;
                state_next  = S_EMIT;
            end
            S_TK_SPAN:
            begin
                if (sub_borrow)
                begin
                    res_hold_next = mk_res(KIND_TAKE, ST_OK, '0, 1'b0, 1'b1);
                    state_next    = S_EMIT;
                end
                else
                begin
                    if (sub_diff >= TIME_W'(WHEEL_SLOTS - 1))
                    begin
                        rem_next = SW'(WHEEL_SLOTS - 1);
                    end
                    else
                    begin
                        rem_next = sub_diff[SW-1:0];
                    end
                    cur_next        = start_slot_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_TS_RD;
                end
            end
            S_TS_RD:
            begin
                state_next = S_TS_HEAD;
            end
            S_TS_HEAD:
            begin
                slot_we = 1'b1;             // slot drained: mark empty
                h_next  = rd_head;
                state_next = rd_head[HW] ? S_TK_NEXT : S_TH_RD;
            end
            S_TH_RD:
            begin
                h_raddr    = h_reg[HW-1:0];
                state_next = S_TH_DATA;
            end
            S_TH_DATA:
            begin
                n_next     = next_rd;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                hslot_we   = 1'b1;
                state_next = S_TH_EMIT;
            end
            S_TH_EMIT:
            begin
                // hold each handle back one step so the final one gets last
                if (!pend_valid_reg || out_free)
                begin
                    out_load = pend_valid_reg;
                    out_word = mk_res(KIND_TAKE, ST_OK, HANDLE_W'(pend_reg), 1'b1, 1'b0);
                    pend_next       = h_reg[HW-1:0];
                    pend_valid_next = 1'b1;
                    h_next          = n_reg;
                    state_next      = n_reg[HW] ? S_TK_NEXT : S_TH_RD;
                end
            end
            S_TK_NEXT:
            begin
                if (rem_reg == '0)
                begin
                    start_ms_next   = cmd_reg.now_ms;
                    start_slot_next = cur_reg;
                    state_next      = S_TK_FIN;
                end
                else
                begin
                    rem_next   = rem_reg - 1'b1;
                    cur_next   = (cur_reg == SW'(WHEEL_SLOTS - 1)) ? '0 : cur_reg + 1'b1;
                    state_next = S_TS_RD;
                end
            end
            S_TK_FIN:
            begin
                res_hold_next = mk_res(KIND_TAKE, ST_OK,
                                       pend_valid_reg ? HANDLE_W'(pend_reg) : '0,
                                       pend_valid_reg, 1'b1);
                pend_valid_next = 1'b0;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_word   = res_hold_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            start_ms_reg   <= '0;
            start_slot_reg <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            start_ms_reg   <= start_ms_next;
            start_slot_reg <= start_slot_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tgt_reg      <= tgt_next;
        cur_reg      <= cur_next;
        rem_reg      <= rem_next;
        hs_reg       <= hs_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        h_reg        <= h_next;
        pend_reg     <= pend_next;
        res_hold_reg <= res_hold_next;
        if (out_load)
        begin
            res_reg <= out_word;
        end
    end

`ifndef NO_ASSERTIONS
    // the output register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result word overwritten while stalled");

    // handles only come from take, and add/cancel answers are single words
    a_handle_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.expired_valid |-> res.kind == KIND_TAKE)
        else $error("expired handle on non-take word");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == KIND_ADD || res.kind == KIND_CANCEL) |-> res.last)
        else $error("add or cancel word without last");

    // a held-back handle exists only while a take walks the wheel
    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_TS_RD || state_reg == S_TS_HEAD ||
                            state_reg == S_TH_RD || state_reg == S_TH_DATA ||
                            state_reg == S_TH_EMIT || state_reg == S_TK_NEXT ||
                            state_reg == S_TK_FIN))
        else $error("pending handle outside take walk");
`endif

endmodule
`default_nettype wire

[rtl/htw_sub.sv]
// Shared 48-bit subtract/compare unit of the timing wheel sequencer.
// Depends on htw_pkg for the time width.
`default_nettype none
module htw_sub
    import htw_pkg::*;
(
    input  wire logic [TIME_W-1:0] a,
    input  wire logic [TIME_W-1:0] b,
    output logic      [TIME_W-1:0] diff,
    output logic                   borrow
);
    logic [TIME_W:0] full;

    // a - b with borrow out: borrow set means a < b
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[TIME_W-1:0];
    assign borrow = full[TIME_W];
endmodule
`default_nettype wire

[test/hashed_timing_wheel_tb.sv]
// Testbench for hashed_timing_wheel: directed and random command words, checked
// against an in-bench timing wheel model. Depends on htw_pkg and the RTL top.
`timescale 1ns / 1ps
module hashed_timing_wheel_tb;
    import htw_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int TIMERS     = 64;
    localparam int NONE       = 127;
    localparam int UNLINKED   = -1;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_word_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_word_t res;

    hashed_timing_wheel u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Wheel model state
    logic [47:0] mdl_start;
    int          mdl_sidx;
    int          mdl_head [SLOTS];
    int          mdl_tail [SLOTS];
    int          mdl_next [TIMERS];
    int          mdl_prev [TIMERS];
    int          mdl_slot [TIMERS];

    res_word_t   pending_res[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          quiet_cycles;

    function automatic res_word_t make_word(kind_code_t k, status_code_t s, int h,
                                            logic v, logic l);
        res_word_t r;
        r.kind           = k;
        r.status         = s;
        r.expired_handle = h[5:0];
        r.expired_valid  = v;
        r.last           = l;
        return r;
    endfunction

    function automatic void wheel_clear();
        mdl_start = '0;
        mdl_sidx  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_head[i] = NONE;
            mdl_tail[i] = NONE;
        end
        for (int i = 0; i < TIMERS; i++)
        begin
            mdl_next[i] = NONE;
            mdl_prev[i] = NONE;
            mdl_slot[i] = UNLINKED;
        end
    endfunction

    function automatic void wheel_unlink(int h);
        int s;
        int p;
        int n;
        s = mdl_slot[h];
        if (s == UNLINKED)
            return;
        p = mdl_prev[h];
        n = mdl_next[h];
        if (p != NONE) mdl_next[p] = n; else mdl_head[s] = n;
        if (n != NONE) mdl_prev[n] = p; else mdl_tail[s] = p;
        mdl_next[h] = NONE;
        mdl_prev[h] = NONE;
        mdl_slot[h] = UNLINKED;
    endfunction

    // Works out the result words of one accepted command and updates the model.
    function automatic void wheel_predict(cmd_word_t w);
        logic [47:0]  diff;
        logic [63:0]  span;
        status_code_t st;
        int           idx;
        int           h;
        int           n;
        int           t;
        int           cnt;
        res_word_t    q[$];
        case (cmd_code_t'(w.command))
            CMD_ADD:
            begin
                if (mdl_start == 0)
                begin
                    mdl_start = w.now_ms;
                    mdl_sidx  = 0;
                end
                if (w.now_ms < mdl_start)
                    st = ST_EARLY;
                else if (w.expire_ms < w.now_ms)
                    st = ST_PAST;
                else
                begin
                    diff = w.expire_ms - mdl_start;
                    if (diff >= SLOTS)
                        st = ST_BEYOND;
                    else
                    begin
                        st  = ST_OK;
                        h   = w.timer_handle;
                        idx = (mdl_sidx + int'(diff)) % SLOTS;
                        // a handle already on the wheel stays put
                        if (mdl_slot[h] == UNLINKED)
                        begin
                            t = mdl_tail[idx];
                            mdl_next[h] = NONE;
                            if (t != NONE)
                            begin
                                mdl_next[t] = h;
                                mdl_prev[h] = t;
                            end
                            else
                            begin
                                mdl_head[idx] = h;
                                mdl_prev[h]   = NONE;
                            end
                            mdl_tail[idx] = h;
                            mdl_slot[h]   = idx;
                        end
                    end
                end
                pending_res.push_back(make_word(KIND_ADD, st, 0, 1'b0, 1'b1));
            end
            CMD_TAKE:
            begin
                if (mdl_start == 0)
                begin
                    mdl_start = w.now_ms;
                    mdl_sidx  = 0;
                end
                if (w.now_ms >= mdl_start)
                begin
                    span = {16'h0, w.now_ms} - {16'h0, mdl_start} + 64'd1;
                    cnt  = (span > SLOTS) ? SLOTS : int'(span);
                    for (int i = 0; i < cnt; i++)
                    begin
                        idx = (mdl_sidx + i) % SLOTS;
                        h   = mdl_head[idx];
                        while (h != NONE)
                        begin
                            n = mdl_next[h];
                            q.push_back(make_word(KIND_TAKE, ST_OK, h, 1'b1, 1'b0));
                            mdl_next[h] = NONE;
                            mdl_prev[h] = NONE;
                            mdl_slot[h] = UNLINKED;
                            h = n;
                        end
                        mdl_head[idx] = NONE;
                        mdl_tail[idx] = NONE;
                    end
                    mdl_start = w.now_ms;
                    mdl_sidx  = (mdl_sidx + cnt - 1) % SLOTS;
                end
                if (q.size() == 0)
                    q.push_back(make_word(KIND_TAKE, ST_OK, 0, 1'b0, 1'b1));
                else
                    q[q.size()-1].last = 1'b1;
                foreach (q[i])
                    pending_res.push_back(q[i]);
            end
            CMD_CANCEL:
            begin
                wheel_unlink(w.timer_handle);
                pending_res.push_back(make_word(KIND_CANCEL, ST_OK, 0, 1'b0, 1'b1));
            end
            default: ;  // unused code: no word back
        endcase
    endfunction

    // Offers one command word, with a random gap first, until the block takes it.
    task automatic send_cmd(cmd_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        wheel_predict(w);
    endtask

    task automatic send_fields(cmd_code_t c, logic [47:0] now_v, logic [47:0] exp_v,
                               int h);
        cmd_word_t w;
        w.command      = c;
        w.now_ms       = now_v;
        w.expire_ms    = exp_v;
        w.timer_handle = h[5:0];
        send_cmd(w);
    endtask

    // Drops valid and waits for every expected word, then lets the block settle.
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Mostly well-formed traffic around the current wheel start, some noise.
    task automatic send_random();
        logic [47:0] base;
        logic [47:0] now_v;
        int          r;
        base = (mdl_start == 0) ? 48'd100 : mdl_start;
        r    = $urandom_range(99);
        if (r < 40)
        begin
            now_v = base + $urandom_range(3);
            send_fields(CMD_ADD, now_v, now_v + $urandom_range(30), $urandom_range(63));
        end
        else if (r < 55)
        begin
            case ($urandom_range(2))
                0: send_fields(CMD_ADD, base, base - 1 - $urandom_range(5),
                               $urandom_range(63));
                1: send_fields(CMD_ADD, base - 1, base + 3, $urandom_range(63));
                default: send_fields(CMD_ADD, base, base + SLOTS + $urandom_range(500),
                                     $urandom_range(63));
            endcase
        end
        else if (r < 75)
        begin
            // rare long jumps walk at least 101 slots, up to the whole wheel
            if ($urandom_range(99) < 3)
                now_v = base + $urandom_range(1500, 100);
            else
                now_v = base + $urandom_range(20);
            send_fields(CMD_TAKE, now_v, 48'({$urandom, $urandom}), $urandom_range(63));
        end
        else if (r < 90)
            send_fields(CMD_CANCEL, base, 48'({$urandom, $urandom}), $urandom_range(63));
        else if (r < 96)
            send_fields(CMD_TAKE, base - 1 - $urandom_range(10), 48'd0, 0);
        else
            send_fields(CMD_NONE, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        $urandom_range(63));
    endtask

    task automatic test_directed();
        send_fields(CMD_TAKE,   48'd0,   48'd0,    0);   // not started, nothing due
        send_fields(CMD_ADD,    48'd100, 48'd100,  0);   // starts the wheel
        send_fields(CMD_ADD,    48'd100, 48'd1123, 1);   // last slot in range
        send_fields(CMD_ADD,    48'd100, 48'd1124, 2);   // one full turn ahead
        send_fields(CMD_ADD,    48'd99,  48'd200,  3);   // now before start
        send_fields(CMD_ADD,    48'd150, 48'd149,  4);   // expiry in past
        send_fields(CMD_ADD,    48'd100, 48'd105,  0);   // already linked, stays
        send_fields(CMD_ADD,    48'd100, 48'd105,  63);
        send_fields(CMD_ADD,    48'd100, 48'd105,  5);
        send_fields(CMD_ADD,    48'd100, 48'd105,  6);
        send_fields(CMD_CANCEL, 48'd100, 48'd0,    5);   // middle of a list
        send_fields(CMD_CANCEL, 48'd100, 48'd0,    5);   // now unlinked
        send_fields(CMD_CANCEL, 48'd100, 48'd0,    7);   // never linked
        send_fields(CMD_NONE,   TMAX,    TMAX,     63);  // unused code
        send_fields(CMD_TAKE,   48'd50,  48'd0,    0);   // take before start
        send_fields(CMD_TAKE,   48'd105, 48'd0,    0);   // drains 0, 63, 6
        send_fields(CMD_ADD,    48'd105, TMAX,     8);   // far beyond
        send_fields(CMD_TAKE,   48'd106, 48'd0,    0);
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_random();
        wait_drained();
    endtask

    // Receiver holds off while random commands keep coming, so the block backs up.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        repeat (20) send_random();
        wait_drained();
    endtask

    // Top of the time range: full-turn take, then add and take at the maximum.
    task automatic test_time_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_fields(CMD_TAKE, TMAX, 48'd0, 0);
        send_fields(CMD_ADD,  TMAX, TMAX, 9);
        send_fields(CMD_ADD,  TMAX, TMAX, 10);
        send_fields(CMD_TAKE, TMAX, TMAX, 63);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", res);
            end
            else
            begin
                want = pending_res.pop_front();
                if (res !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: kind %0d/%0d status %0d/%0d handle %0d/%0d valid %0d/%0d last %0d/%0d (exp/act)",
                                 want.kind, res.kind, want.status, res.status,
                                 want.expired_handle, res.expired_handle,
                                 want.expired_valid, res.expired_valid,
                                 want.last, res.last);
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("hashed_timing_wheel_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        res_stall      = 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        wheel_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(0, 0, 50);
        test_random_phase(47, 0, 50);
        test_random_phase(0, 47, 50);
        test_random_phase(11, 11, 50);
        test_backpressure();
        test_time_extremes();

        if (pending_res.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("hashed_timing_wheel_tb passed");
        else
            $display("hashed_timing_wheel_tb failed");
        $finish;
    end

endmodule

[hashed_timing_wheel.f]
rtl/htw_pkg.sv
rtl/htw_sub.sv
rtl/hashed_timing_wheel.sv
test/hashed_timing_wheel_tb.sv
